// File: src/lssd_pkg.sv
// ----------------------------------------------------------------------------
// lssd_pkg
// Shared constants and payload types for the longest divisible-sum run block.
// ----------------------------------------------------------------------------
`default_nettype none

package lssd_pkg;

  localparam int K_MAX = 1024;
  localparam int N_MAX = 65536;

  localparam int VW  = 32;                 // element width
  localparam int CW  = $clog2(VW);         // bit counter of the serial reducer
  localparam int KW  = $clog2(K_MAX) + 1;  // modulus register width
  localparam int RW  = $clog2(K_MAX);      // residue width, table index
  localparam int PW  = $clog2(N_MAX) + 1;  // position and length width
  localparam int FPW = $clog2(N_MAX);      // stored first position width
  localparam int EPW = 8;                  // epoch tag width
  localparam int MW  = EPW + FPW;          // table word: {tag, first position}

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic [PW-1:0] length;
    logic          overflow;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic signed [VW-1:0] value;
    logic [RW-1:0]        residue;
    logic [KW-1:0]        k;
  } red_req_t;

  typedef struct packed {
    logic          done;
    logic [RW-1:0] residue;
  } red_rsp_t;

endpackage

`default_nettype wire

// File: src/lssd_reduce.sv
// ----------------------------------------------------------------------------
// lssd_reduce
// Bit-serial modular reducer: new prefix residue = (residue + value) mod k.
// ----------------------------------------------------------------------------
`default_nettype none

module lssd_reduce (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire lssd_pkg::red_req_t  req,
  output lssd_pkg::red_rsp_t       rsp
);
  import lssd_pkg::*;

  logic              busy_r, busy_nxt;
  logic              fix_r, fix_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [VW-1:0]     mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [RW-1:0]     vrem_r, vrem_nxt;
  logic [RW-1:0]     rsh_r, rsh_nxt;
  logic [RW-1:0]     rrem_r, rrem_nxt;
  logic [RW-1:0]     res_r, res_nxt;

  logic [KW-1:0]     vt, vn, rt, rn;
  logic [KW-1:0]     vfix, sum, sred;

  always_comb begin
    // one remainder step per bit: shift in, subtract k when reached
    vt = {vrem_r, mag_r[VW-1]};
    vn = (vt >= k_r) ? vt - k_r : vt;
    rt = {rrem_r, rsh_r[RW-1]};
    rn = (rt >= k_r) ? rt - k_r : rt;

    // negative element: residue of the magnitude is folded to k - r
    vfix = (neg_r && (vrem_r != '0)) ? k_r - {1'b0, vrem_r} : {1'b0, vrem_r};
    sum  = {1'b0, rrem_r} + vfix;
    sred = (sum >= k_r) ? sum - k_r : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    k_nxt    = k_r;
    vrem_nxt = vrem_r;
    rsh_nxt  = rsh_r;
    rrem_nxt = rrem_r;
    res_nxt  = res_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = req.value[VW-1];
      mag_nxt  = req.value[VW-1] ? VW'(~req.value + 1'b1) : VW'(req.value);
      k_nxt    = req.k;
      vrem_nxt = '0;
      rsh_nxt  = req.residue;
      rrem_nxt = '0;
    end else if (busy_r) begin
      mag_nxt  = {mag_r[VW-2:0], 1'b0};
      vrem_nxt = vn[RW-1:0];
      // stored residue has only RW bits: reduce it during the first RW steps
      if (cnt_r < CW'(RW)) begin
        rsh_nxt  = {rsh_r[RW-2:0], 1'b0};
        rrem_nxt = rn[RW-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      res_nxt  = sred[RW-1:0];
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    k_r    <= k_nxt;
    vrem_r <= vrem_nxt;
    rsh_r  <= rsh_nxt;
    rrem_r <= rrem_nxt;
    res_r  <= res_nxt;
  end

  assign rsp = {done_r, res_r};

endmodule

`default_nettype wire

// File: src/longest_subarray_sum_divisible.sv
// ----------------------------------------------------------------------------
// longest_subarray_sum_divisible
// Longest contiguous run of a streamed array whose sum divides by a modulus.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  in_      | input     | in_valid / in_stall  | in_item_t  {value, last}
//  out_     | output    | out_valid / out_stall| out_item_t {length, overflow}
//  cfg_     | input     | cfg_valid / cfg_ready| modulus, 11 bits
//
//  An element runs through these steps before the next input transaction:
//  the bit-serial remainder, a step to fold the sign and add the prior
//  residue, a table read, an update and write, a finish and an idle step to
//  take the next. Elements past the position limit or with modulus zero go
//  straight to the finish. After reset, and after every 255th array, a
//  clearing pass sweeps the 1024-entry first-position table with in_stall high.
//  A result waits in the output register; a stalled output holds the block
//  only when a further result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_subarray_sum_divisible (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire lssd_pkg::in_item_t     in_data,
  output logic                        out_valid,
  input  wire                         out_stall,
  output lssd_pkg::out_item_t         out_data,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [lssd_pkg::KW-1:0]      cfg_data
);
  import lssd_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RED  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [KW-1:0]  modulus_r, modulus_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic           last_r, last_nxt;
  logic [RW-1:0]  residue_r, residue_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [PW-1:0]  best_r, best_nxt;
  logic           ovf_r, ovf_nxt;
  logic [EPW-1:0] epoch_r, epoch_nxt;
  logic [RW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_data_r, out_data_nxt;

  logic [MW-1:0]  mem [K_MAX];
  logic [MW-1:0]  mem_rd_r;
  logic           mem_we;
  logic [RW-1:0]  mem_waddr;
  logic [MW-1:0]  mem_wdata;
  logic [RW-1:0]  mem_raddr;

  red_req_t       req;
  red_rsp_t       rsp;

  logic           in_acc;
  logic [KW-1:0]  k_in;
  logic [PW-1:0]  cand;
  logic           out_free;

  lssd_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign k_in      = (modulus_r > KW'(K_MAX)) ? KW'(K_MAX) : modulus_r;
  assign cand      = pos_r - {1'b0, mem_rd_r[FPW-1:0]};
  assign out_free  = !out_valid_r || !out_stall;
  assign mem_raddr = rsp.residue;

  always_comb begin
    req.start   = 1'b0;
    req.value   = in_data.value;
    req.residue = residue_r;
    req.k       = k_in;

    state_nxt     = state_r;
    modulus_nxt   = (cfg_valid && cfg_ready) ? cfg_data : modulus_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    residue_nxt   = residue_r;
    pos_nxt       = pos_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    epoch_nxt     = epoch_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    mem_we    = 1'b0;
    mem_waddr = residue_r;
    mem_wdata = {epoch_r, pos_r[FPW-1:0]};

    case (state_r)
      ST_CLR: begin
        // tag zero never matches a live epoch
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          k_nxt    = k_in;
          last_nxt = in_data.last;
          if (pos_r >= PW'(N_MAX)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else if (k_in == '0) begin
            pos_nxt   = pos_r + 1'b1;
            state_nxt = ST_FIN;
          end else begin
            req.start = 1'b1;
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        // table read at the new residue is issued on the done cycle
        if (rsp.done) begin
          residue_nxt = rsp.residue;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        if (residue_r == '0) begin
          best_nxt = pos_r + 1'b1;
        end else if (mem_rd_r[MW-1:FPW] != epoch_r) begin
          mem_we = 1'b1;
        end else if (cand > best_r) begin
          best_nxt = cand;
        end
        pos_nxt   = pos_r + 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.length   = (k_r == '0) ? '0 : best_r;
          out_data_nxt.overflow = ovf_r;
          residue_nxt           = '0;
          pos_nxt               = '0;
          best_nxt              = '0;
          ovf_nxt               = 1'b0;
          // advance the epoch; sweep the table when tags run out
          if (epoch_r == '1) begin
            epoch_nxt   = EPW'(1);
            clr_cnt_nxt = '0;
            state_nxt   = ST_CLR;
          end else begin
            epoch_nxt = epoch_r + 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      modulus_r   <= KW'(1);
      residue_r   <= '0;
      pos_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      epoch_r     <= EPW'(1);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      residue_r   <= residue_nxt;
      pos_r       <= pos_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      epoch_r     <= epoch_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: src/lssd_checker.sv
// ----------------------------------------------------------------------------
// lssd_checker
// Port-level checks on the longest divisible-sum run block.
// ----------------------------------------------------------------------------
`default_nettype none

module lssd_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_stall,
  input wire lssd_pkg::in_item_t     in_data,
  input wire                         out_valid,
  input wire                         out_stall,
  input wire lssd_pkg::out_item_t    out_data,
  input wire                         cfg_valid,
  input wire                         cfg_ready,
  input wire [lssd_pkg::KW-1:0]      cfg_data
);
  import lssd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // one element at a time: an accepted transaction closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // a new result is raised only while the input is stalled
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(in_stall))
    else $error("result raised while idle");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.length <= PW'(N_MAX))
    else $error("length beyond limit");

endmodule

bind longest_subarray_sum_divisible lssd_checker u_lssd_checker (.*);

`default_nettype wire
